### hdl/pomg_pkg.sv
// Shared types, constants and helpers of the point occupancy grid marker.
// Used by the front part, the back part, the top level and the bench; depends on nothing.
package pomg_pkg;

  // Default structural sizes, handed to the top level parameters.
  localparam int MAX_GRID_SIDE_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;

  // Cell store: one 2-bit cell for every 16-bit linear index.
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = 16;
  localparam int CELL_W      = 2;

  // Configuration register widths and reset values.
  localparam int CPM_W     = 10;
  localparam int HALF_W    = 15;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  localparam logic [CPM_W-1:0]  CPM_RESET  = 10'd10;
  localparam logic [HALF_W-1:0] HALF_RESET = 15'd10000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd201;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CPM         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd4;

  // Input command codes.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Operations handed from the front part to the back part.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Stored cell codes.
  localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
  localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

  // Cell values as they leave the block.
  localparam logic signed [7:0] VALUE_UNKNOWN  = -8'sd1;
  localparam logic signed [7:0] VALUE_FREE     = 8'sd0;
  localparam logic signed [7:0] VALUE_OCCUPIED = 8'sd100;

  // Grid centre offset: half of 1000 mm per cell step.
  localparam int CENTRE_MM = 500;

  // Signed width of a scaled coordinate plus centre offset. A kept point has
  // |coordinate| <= 32767, so the sum stays below 2^26 for the default largest side.
  localparam int N_W = 27;

  // Floor division by 1000 of a non-negative value below 2^25 is a multiply
  // by ceil(2^35 / 1000) and a shift by 35; the result is exact in that range.
  localparam int              RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 26'd34359739;
  localparam int              RECIP_SHIFT = 35;
  localparam int              Q_W         = 16;

  // One operation for the back part.
  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic              obstacle;
  } pomg_req_t;

  // Status of the back part seen by the top level.
  typedef struct packed {
    logic sweeping;
  } pomg_status_t;

  // Translate a stored cell code into its output value.
  function automatic logic signed [7:0] cell_value_of(input logic [CELL_W-1:0] code);
    logic signed [7:0] v;
    case (code)
      CELL_FREE:     v = VALUE_FREE;
      CELL_OCCUPIED: v = VALUE_OCCUPIED;
      default:       v = VALUE_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

### hdl/pomg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module pomg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pomg_fifo.sv
// Short request queue between the front and the back part.
// Depends on nothing.
module pomg_fifo #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hdl/pomg_front.sv
// Front part: accepts input items, range-checks points and maps them to a cell
// index over a five-stage pipeline. Depends on pomg_pkg.
module pomg_front #(
  parameter int MAX_GRID_SIDE = pomg_pkg::MAX_GRID_SIDE_DEF,
  parameter int COORD_BITS    = pomg_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic [1:0]                           command,
  input  logic signed [COORD_BITS-1:0]         x_mm,
  input  logic signed [COORD_BITS-1:0]         y_mm,
  input  logic                                 is_obstacle,
  input  logic [pomg_pkg::ADDR_W-1:0]          read_index,
  input  logic [pomg_pkg::CPM_W-1:0]           cells_per_metre,
  input  logic [pomg_pkg::HALF_W-1:0]          half_width_mm,
  input  logic [pomg_pkg::HALF_W-1:0]          half_height_mm,
  input  logic [$clog2(MAX_GRID_SIDE+1)-1:0]   grid_w,
  input  logic [$clog2(MAX_GRID_SIDE+1)-1:0]   grid_h,
  output logic                                 req_valid,
  input  logic                                 req_ready,
  output pomg_pkg::pomg_req_t                  req
);

  import pomg_pkg::*;

  localparam int SIDE_W  = $clog2(MAX_GRID_SIDE + 1);
  localparam int CMP_W   = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
  localparam int CE_W    = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int IDX_W   = 2 * SIDE_W + 1;
  localparam int IDXE_W  = (IDX_W > ADDR_W) ? IDX_W : ADDR_W + 1;
  localparam int PROD_W  = (N_W - 1) + RECIP_W;

  logic adv;

  // Stage valid bits and request payloads.
  logic      v1, v2, v3, v4, v5;
  pomg_req_t q1, q2, q3, q4, q5;

  logic signed [N_W-1:0]  px1, py1;
  logic signed [N_W-1:0]  nx2, ny2;
  logic [PROD_W-1:0]      mx3, my3;
  logic [SIDE_W-1:0]      col4;
  logic [2*SIDE_W-1:0]    rw4;

  // Stage 1 combinational signals.
  logic [COORD_BITS-1:0]  ax, ay;
  logic                   in_range;
  logic signed [CE_W-1:0] x_e, y_e;
  logic signed [15:0]     x16, y16;
  logic signed [N_W-1:0]  px, py;
  pomg_req_t              q1_next;

  // Later stage combinational signals.
  logic [N_W-2:0]         off_x, off_y;
  logic signed [N_W-1:0]  nx, ny;
  pomg_req_t              q3_next;
  logic [PROD_W-1:0]      mx, my;
  logic [Q_W-1:0]         colq, rowq;
  pomg_req_t              q4_next;
  logic [2*SIDE_W-1:0]    rw;
  logic [IDXE_W-1:0]      idx_e;
  pomg_req_t              q5_next;

  // The whole pipeline moves when its last stage can hand over.
  assign adv        = !v5 || req_ready;
  assign item_ready = adv;
  assign req_valid  = v5;
  assign req        = q5;

  // Stage 1: classify the command, check the range and scale the coordinates.
  always_comb begin
    ax = x_mm[COORD_BITS-1] ? COORD_BITS'(-x_mm) : COORD_BITS'(x_mm);
    ay = y_mm[COORD_BITS-1] ? COORD_BITS'(-y_mm) : COORD_BITS'(y_mm);
    in_range = (CMP_W'(ax) <= CMP_W'(half_width_mm)) &&
               (CMP_W'(ay) <= CMP_W'(half_height_mm));
    x_e = CE_W'(x_mm);
    y_e = CE_W'(y_mm);
    x16 = signed'(x_e[15:0]);
    y16 = signed'(y_e[15:0]);
    px  = N_W'(x16) * N_W'($signed({1'b0, cells_per_metre}));
    py  = N_W'(y16) * N_W'($signed({1'b0, cells_per_metre}));
    q1_next.addr     = read_index;
    q1_next.obstacle = is_obstacle;
    case (command)
      CMD_CLEAR: q1_next.op = OP_CLEAR;
      CMD_MARK:  q1_next.op = in_range ? OP_MARK : OP_NONE;
      CMD_READ:  q1_next.op = OP_READ;
      default:   q1_next.op = OP_NONE;
    endcase
  end

  // Stage 2: add the centre offset of the grid.
  always_comb begin
    off_x = (N_W-1)'(grid_w) * (N_W-1)'(CENTRE_MM);
    off_y = (N_W-1)'(grid_h) * (N_W-1)'(CENTRE_MM);
    nx    = px1 + $signed({1'b0, off_x});
    ny    = py1 + $signed({1'b0, off_y});
  end

  // Stage 3: a negative sum lies left of or below the grid; else divide by 1000.
  always_comb begin
    q3_next = q2;
    if (q2.op == OP_MARK && (nx2[N_W-1] || ny2[N_W-1])) begin
      q3_next.op = OP_NONE;
    end
    mx = PROD_W'(nx2[N_W-2:0]) * PROD_W'(RECIP_1000);
    my = PROD_W'(ny2[N_W-2:0]) * PROD_W'(RECIP_1000);
  end

  // Stage 4: check column and row against the grid and form the row offset.
  always_comb begin
    colq    = mx3[RECIP_SHIFT +: Q_W];
    rowq    = my3[RECIP_SHIFT +: Q_W];
    q4_next = q3;
    if (q3.op == OP_MARK && (colq >= Q_W'(grid_w) || rowq >= Q_W'(grid_h))) begin
      q4_next.op = OP_NONE;
    end
    rw = (2*SIDE_W)'(rowq[SIDE_W-1:0]) * (2*SIDE_W)'(grid_w);
  end

  // Stage 5: linear index and store depth check.
  always_comb begin
    idx_e   = IDXE_W'(rw4) + IDXE_W'(col4);
    q5_next = q4;
    if (q4.op == OP_MARK) begin
      if (idx_e[IDXE_W-1:ADDR_W] != '0) begin
        q5_next.op = OP_NONE;
      end else begin
        q5_next.addr = idx_e[ADDR_W-1:0];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      q1   <= q1_next;
      px1  <= px;
      py1  <= py;
      q2   <= q1;
      nx2  <= nx;
      ny2  <= ny;
      q3   <= q3_next;
      mx3  <= mx;
      my3  <= my;
      q4   <= q4_next;
      col4 <= colq[SIDE_W-1:0];
      rw4  <= rw;
      q5   <= q5_next;
    end
  end

endmodule

### hdl/pomg_back.sv
// Back part: carries out clear, mark and read requests on the cell store and
// holds the result register. Depends on pomg_pkg and pomg_ram.
module pomg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  pomg_pkg::pomg_req_t           req,
  output pomg_pkg::pomg_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          point_kept,
  output logic [pomg_pkg::ADDR_W-1:0]   cell_index,
  output logic signed [7:0]             cell_value
);

  import pomg_pkg::*;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]        state;
  logic [ADDR_W-1:0] cnt;
  pomg_req_t         hold;
  logic              pop;
  logic              out_valid_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rdata;
  logic [CELL_W-1:0] new_code;

  pomg_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (req.addr),
    .rdata (rdata)
  );

  // A new request is taken only when the result register is free or emptying.
  assign pop             = (state == ST_IDLE) && req_valid && (!out_valid || out_ready);
  assign req_ready       = pop;
  assign status.sweeping = (state == ST_SWEEP);

  // Occupied wins over free whatever the order of arrival.
  assign new_code = hold.obstacle ? CELL_OCCUPIED :
                    ((rdata == CELL_OCCUPIED) ? CELL_OCCUPIED : CELL_FREE);

  // Store write port: the clearing sweep or the write-back of a mark.
  always_comb begin
    we    = 1'b0;
    waddr = hold.addr;
    wdata = new_code;
    if (state == ST_SWEEP) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = CELL_UNKNOWN;
    end else if (state == ST_WAIT && hold.op == OP_MARK) begin
      we = 1'b1;
    end
  end

  // Result valid flag: cleared when taken, set whenever a result is loaded.
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (state == ST_WAIT) begin
      out_valid_next = 1'b1;
    end else if (pop && req.op != OP_MARK && req.op != OP_READ) begin
      out_valid_next = 1'b1;
    end
  end

  // Sequencer and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            case (req.op)
              OP_CLEAR: begin
                cnt   <= '0;
                state <= ST_SWEEP;
              end
              OP_MARK, OP_READ: begin
                state <= ST_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WAIT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Held request and result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= req;
      if (req.op == OP_CLEAR) begin
        point_kept <= 1'b0;
        cell_index <= '0;
        cell_value <= VALUE_UNKNOWN;
      end else if (req.op == OP_NONE) begin
        point_kept <= 1'b0;
        cell_index <= '0;
        cell_value <= VALUE_FREE;
      end
    end
    if (state == ST_WAIT) begin
      point_kept <= (hold.op == OP_MARK);
      cell_index <= hold.addr;
      cell_value <= (hold.op == OP_MARK) ? cell_value_of(new_code) : cell_value_of(rdata);
    end
  end

  // The result register is always empty while a store read is outstanding.
  a_wait_out_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> !out_valid)
    else $error("result register busy during store read");

  // A kept point always reports free or occupied.
  a_kept_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_kept |-> (cell_value == VALUE_FREE || cell_value == VALUE_OCCUPIED))
    else $error("kept point with unknown cell value");

  // The sweep ends after the last store entry.
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP && cnt == '1 |=> state == ST_IDLE)
    else $error("clearing sweep did not finish");

  // A clear request starts a sweep and reports the unknown value.
  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    pop && req.op == OP_CLEAR |=> state == ST_SWEEP && out_valid &&
                                  cell_value == VALUE_UNKNOWN)
    else $error("clear request not carried out");

endmodule

### hdl/point_occupancy_grid_marker_top.sv
// Point occupancy grid marker: a mark or read request passes 5 front pipeline stages,
// the queue, the store read and write-back before its result is registered.
// The store sequencer takes no new request while a mark or read waits on its store read;
// the front takes one a cycle, while the 4-entry queue has room, into that queue.
// A clear request sweeps the whole store, one store entry a cycle.
// After reset the configuration holds its defaults and a clearing pass over the store
// runs with in_ready low; configuration writes are taken throughout.
module point_occupancy_grid_marker_top #(
  parameter int MAX_GRID_SIDE = pomg_pkg::MAX_GRID_SIDE_DEF,
  parameter int COORD_BITS    = pomg_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pomg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pomg_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic signed [COORD_BITS-1:0]      x_mm,
  input  logic signed [COORD_BITS-1:0]      y_mm,
  input  logic                              is_obstacle,
  input  logic [pomg_pkg::ADDR_W-1:0]       read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              point_kept,
  output logic [pomg_pkg::ADDR_W-1:0]       cell_index,
  output logic signed [7:0]                 cell_value
);

  import pomg_pkg::*;

  localparam int SIDE_W    = $clog2(MAX_GRID_SIDE + 1);
  localparam int FIFO_DEPTH = 4;

  logic [CPM_W-1:0]   cells_per_metre;
  logic [HALF_W-1:0]  half_width_mm;
  logic [HALF_W-1:0]  half_height_mm;
  logic [SIZE_W-1:0]  grid_width_cells;
  logic [SIZE_W-1:0]  grid_height_cells;

  logic [SIDE_W-1:0]  grid_w;
  logic [SIDE_W-1:0]  grid_h;

  pomg_status_t status;
  logic         front_valid;
  logic         front_ready;
  logic         fr_valid;
  logic         fr_ready;
  pomg_req_t    fr_req;
  logic         bk_valid;
  logic         bk_ready;
  pomg_req_t    bk_req;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_metre   <= CPM_RESET;
      half_width_mm     <= HALF_RESET;
      half_height_mm    <= HALF_RESET;
      grid_width_cells  <= SIZE_RESET;
      grid_height_cells <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CPM:         cells_per_metre   <= cfg_data[CPM_W-1:0];
        CFG_HALF_WIDTH:  half_width_mm     <= cfg_data[HALF_W-1:0];
        CFG_HALF_HEIGHT: half_height_mm    <= cfg_data[HALF_W-1:0];
        CFG_GRID_WIDTH:  grid_width_cells  <= cfg_data[SIZE_W-1:0];
        CFG_GRID_HEIGHT: grid_height_cells <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Grid sizes clamped to one up to the largest grid side.
  always_comb begin
    if (grid_width_cells == '0) begin
      grid_w = SIDE_W'(1);
    end else if (32'(grid_width_cells) > 32'(MAX_GRID_SIDE)) begin
      grid_w = SIDE_W'(MAX_GRID_SIDE);
    end else begin
      grid_w = SIDE_W'(grid_width_cells);
    end
    if (grid_height_cells == '0) begin
      grid_h = SIDE_W'(1);
    end else if (32'(grid_height_cells) > 32'(MAX_GRID_SIDE)) begin
      grid_h = SIDE_W'(MAX_GRID_SIDE);
    end else begin
      grid_h = SIDE_W'(grid_height_cells);
    end
  end

  // No request is taken while the store is being swept.
  assign front_valid = in_valid && !status.sweeping;
  assign in_ready    = front_ready && !status.sweeping;

  pomg_front #(
    .MAX_GRID_SIDE (MAX_GRID_SIDE),
    .COORD_BITS    (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (front_valid),
    .item_ready      (front_ready),
    .command         (command),
    .x_mm            (x_mm),
    .y_mm            (y_mm),
    .is_obstacle     (is_obstacle),
    .read_index      (read_index),
    .cells_per_metre (cells_per_metre),
    .half_width_mm   (half_width_mm),
    .half_height_mm  (half_height_mm),
    .grid_w          (grid_w),
    .grid_h          (grid_h),
    .req_valid       (fr_valid),
    .req_ready       (fr_ready),
    .req             (fr_req)
  );

  pomg_fifo #(
    .WIDTH ($bits(pomg_req_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_req),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_req)
  );

  pomg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (bk_valid),
    .req_ready  (bk_ready),
    .req        (bk_req),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_kept (point_kept),
    .cell_index (cell_index),
    .cell_value (cell_value)
  );

endmodule

### dv/tb_point_occupancy_grid_marker_top.sv
// Self-checking bench for the point occupancy grid marker top level.
// A scoreboard class keeps its own copy of the grid and the settings and
// predicts every result; depends on pomg_pkg and point_occupancy_grid_marker_top.
module tb_point_occupancy_grid_marker_top;
  import pomg_pkg::*;

  localparam logic [1:0]           CMD_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd7;
  localparam int                   STALL_LIMIT   = 262144;
  localparam int                   SETTLE_CYCLES = 16;

  typedef struct {
    logic              kept;
    logic [ADDR_W-1:0] index;
    logic signed [7:0] value;
  } cell_result_t;

  // Grid predictor and store of the results still due from the block.
  class grid_scoreboard;
    int                cpm;
    int                half_w;
    int                half_h;
    int                grid_w;
    int                grid_h;
    logic [CELL_W-1:0] cells [STORE_DEPTH];
    cell_result_t      due_q [$];
    int                error_count;

    function new();
      cpm         = CPM_RESET;
      half_w      = HALF_RESET;
      half_h      = HALF_RESET;
      grid_w      = SIZE_RESET;
      grid_h      = SIZE_RESET;
      error_count = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (cells[i]) cells[i] = CELL_UNKNOWN;
    endfunction

    // Grid sides in use are held within 1 and the largest side.
    function int side(int s);
      if (s < 1) return 1;
      if (s > MAX_GRID_SIDE_DEF) return MAX_GRID_SIDE_DEF;
      return s;
    endfunction

    // Division by 1000 rounded towards minus infinity.
    function longint floor_thousandth(longint n);
      longint q;
      q = n / 1000;
      if ((n % 1000) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function logic signed [7:0] value_of(logic [CELL_W-1:0] code);
      case (code)
        CELL_FREE:     return VALUE_FREE;
        CELL_OCCUPIED: return VALUE_OCCUPIED;
        default:       return VALUE_UNKNOWN;
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_CPM:         cpm    = data[CPM_W-1:0];
        CFG_HALF_WIDTH:  half_w = data[HALF_W-1:0];
        CFG_HALF_HEIGHT: half_h = data[HALF_W-1:0];
        CFG_GRID_WIDTH:  grid_w = data[SIZE_W-1:0];
        CFG_GRID_HEIGHT: grid_h = data[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the grid and queue the result it causes.
    function void note_request(logic [1:0] cmd, logic signed [15:0] x,
                               logic signed [15:0] y, logic obstacle,
                               logic [ADDR_W-1:0] ridx);
      cell_result_t r;
      longint       xs, ys, w, h, col, row, idx;
      r.kept  = 1'b0;
      r.index = '0;
      r.value = '0;
      case (cmd)
        CMD_CLEAR: begin
          wipe();
          r.value = VALUE_UNKNOWN;
        end
        CMD_MARK: begin
          xs = x;
          ys = y;
          w  = side(grid_w);
          h  = side(grid_h);
          // A point outside the half extents or outside the grid is dropped.
          if ((xs < 0 ? -xs : xs) <= half_w && (ys < 0 ? -ys : ys) <= half_h) begin
            col = floor_thousandth(xs * cpm + CENTRE_MM * w);
            row = floor_thousandth(ys * cpm + CENTRE_MM * h);
            idx = row * w + col;
            if (col >= 0 && col < w && row >= 0 && row < h && idx < STORE_DEPTH) begin
              // Occupied is never downgraded to free.
              if (obstacle) cells[idx] = CELL_OCCUPIED;
              else if (cells[idx] != CELL_OCCUPIED) cells[idx] = CELL_FREE;
              r.kept  = 1'b1;
              r.index = idx[ADDR_W-1:0];
              r.value = value_of(cells[idx]);
            end
          end
        end
        CMD_READ: begin
          r.index = ridx;
          r.value = value_of(cells[ridx]);
        end
        default: ;
      endcase
      due_q.insert(due_q.size(), r);
    endfunction

    // Compare one result with the oldest one due.
    function void check_result(logic kept, logic [ADDR_W-1:0] index,
                               logic signed [7:0] value);
      cell_result_t e;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result: kept %0b index %0d value %0d",
                 $time, kept, index, value);
        error_count++;
        return;
      end
      e = due_q.pop_front();
      if (kept !== e.kept) begin
        $display("%0t: point_kept expected %0b actual %0b", $time, e.kept, kept);
        error_count++;
      end
      if (index !== e.index) begin
        $display("%0t: cell_index expected %0d actual %0d", $time, e.index, index);
        error_count++;
      end
      if (value !== e.value) begin
        $display("%0t: cell_value expected %0d actual %0d", $time, e.value, value);
        error_count++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DAT_W-1:0]    cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              command;
  logic signed [15:0]      x_mm;
  logic signed [15:0]      y_mm;
  logic                    is_obstacle;
  logic [ADDR_W-1:0]       read_index;
  logic                    out_valid;
  logic                    out_ready;
  logic                    point_kept;
  logic [ADDR_W-1:0]       cell_index;
  logic signed [7:0]       cell_value;

  grid_scoreboard sb;
  bit             idling;
  int             clears_left;
  int             hold_off;
  int             quiet_cycles;

  point_occupancy_grid_marker_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .is_obstacle (is_obstacle),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_kept  (point_kept),
    .cell_index  (cell_index),
    .cell_value  (cell_value)
  );

  always #5 clk = ~clk;

  // Result side: ready with random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_off = 0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else if (idling && $urandom_range(7, 0) == 0) begin
      out_ready <= 1'b0;
      hold_off = $urandom_range(10, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watch every handshake and feed the scoreboard in acceptance order.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(command, x_mm, y_mm, is_obstacle, read_index);
      if (out_valid && out_ready) sb.check_result(point_kept, cell_index, cell_value);
    end
  end

  // End the run if nothing moves on any channel for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_point_occupancy_grid_marker_top: done, errors");
    $finish;
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DAT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int cpm, input int hw, input int hh,
                                input int gw, input int gh);
    write_register(CFG_CPM, cpm);
    write_register(CFG_HALF_WIDTH, hw);
    write_register(CFG_HALF_HEIGHT, hh);
    write_register(CFG_GRID_WIDTH, gw);
    write_register(CFG_GRID_HEIGHT, gh);
  endtask

  // Present one request, hold it until taken, then maybe leave a gap.
  task automatic send_request(input logic [1:0] cmd, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic obs,
                              input logic [ADDR_W-1:0] ridx);
    in_valid    <= 1'b1;
    command     <= cmd;
    x_mm        <= x;
    y_mm        <= y;
    is_obstacle <= obs;
    read_index  <= ridx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idling && $urandom_range(5, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until the block has returned everything.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A coordinate that lands in or near a random cell of the grid.
  function automatic logic signed [15:0] coord_in_grid(int cells, int half);
    int c, v;
    c = int'($urandom_range(cells - 1, 0));
    if (sb.cpm == 0)
      v = int'($urandom_range(2 * half, 0)) - half;
    else
      v = (c * 1000 - CENTRE_MM * cells + int'($urandom_range(999, 0))) / sb.cpm;
    if (v > half || v < -half) v = int'($urandom_range(2 * half, 0)) - half;
    return v[15:0];
  endfunction

  // A coordinate on the range limit or just beyond it.
  function automatic logic signed [15:0] coord_at_edge(int half);
    int v;
    v = half + int'($urandom_range(1, 0));
    if (v > 32767) v = 32767;
    if ($urandom_range(1, 0) == 1) v = -v;
    return v[15:0];
  endfunction

  // Mostly well-formed points and reads of the grid in use, some noise.
  task automatic run_random(input int count);
    int                 n, pick, w, h;
    logic [1:0]         cmd;
    logic signed [15:0] x, y;
    logic               obs;
    logic [ADDR_W-1:0]  ridx;
    for (n = 0; n < count; n++) begin
      w    = sb.side(sb.grid_w);
      h    = sb.side(sb.grid_h);
      pick = $urandom_range(99, 0);
      cmd  = CMD_MARK;
      x    = 16'($urandom);
      y    = 16'($urandom);
      obs  = 1'($urandom);
      ridx = ADDR_W'($urandom);
      if (pick < 3) begin
        cmd = CMD_UNUSED;
      end else if (pick == 3) begin
        if (clears_left > 0 && $urandom_range(3, 0) == 0) begin
          cmd = CMD_CLEAR;
          clears_left--;
        end
      end else if (pick < 60) begin
        x = coord_in_grid(w, sb.half_w);
        y = coord_in_grid(h, sb.half_h);
      end else if (pick < 68) begin
        x = coord_at_edge(sb.half_w);
        y = coord_in_grid(h, sb.half_h);
      end else if (pick < 76) begin
        x = coord_in_grid(w, sb.half_w);
        y = coord_at_edge(sb.half_h);
      end else if (pick >= 82) begin
        cmd = CMD_READ;
        if (pick < 92)
          ridx = 16'(int'($urandom_range(h - 1, 0)) * w + int'($urandom_range(w - 1, 0)));
      end
      send_request(cmd, x, y, obs, ridx);
    end
  endtask

  // Main sequence.
  initial begin
    sb          = new();
    idling      = 1'b1;
    clears_left = 3;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    command     <= CMD_CLEAR;
    x_mm        <= '0;
    y_mm        <= '0;
    is_obstacle <= 1'b0;
    read_index  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Default settings written explicitly, then the directed requests.
    apply_settings(CPM_RESET, HALF_RESET, HALF_RESET, SIZE_RESET, SIZE_RESET);
    send_request(CMD_READ, 16'sd0, 16'sd0, 1'b0, 16'd0);
    send_request(CMD_READ, -16'sd1, -16'sd1, 1'b1, 16'hFFFF);
    send_request(CMD_MARK, 16'sd0, 16'sd0, 1'b0, 16'h1234);
    send_request(CMD_MARK, 16'sd0, 16'sd0, 1'b1, 16'd0);
    // A ground point on an occupied cell leaves it occupied.
    send_request(CMD_MARK, 16'sd0, 16'sd0, 1'b0, 16'd0);
    send_request(CMD_MARK, 16'sd10000, 16'sd10000, 1'b0, 16'd0);
    send_request(CMD_MARK, -16'sd10000, -16'sd10000, 1'b1, 16'd0);
    send_request(CMD_MARK, 16'sd10001, 16'sd0, 1'b1, 16'd0);
    send_request(CMD_MARK, 16'sd0, -16'sd10001, 1'b1, 16'd0);
    send_request(CMD_MARK, 16'sd32767, -16'sd32768, 1'b1, 16'hFFFF);
    send_request(CMD_MARK, -16'sd32768, 16'sd32767, 1'b0, 16'hFFFF);
    send_request(CMD_MARK, -16'sd1, -16'sd1, 1'b0, 16'd0);
    send_request(CMD_READ, 16'sd0, 16'sd0, 1'b0, 16'd20200);
    send_request(CMD_READ, 16'sd0, 16'sd0, 1'b0, 16'd0);
    send_request(CMD_READ, 16'sd0, 16'sd0, 1'b0, 16'd40400);
    // The unused command leaves the grid as it is and reports no kept point, whatever its fields hold.
    send_request(CMD_UNUSED, -16'sd1, -16'sd1, 1'b1, 16'hFFFF);
    send_request(CMD_CLEAR, 16'sd5, 16'sd5, 1'b1, 16'd20200);
    send_request(CMD_READ, 16'sd0, 16'sd0, 1'b0, 16'd20200);
    send_request(CMD_MARK, 16'sd50, -16'sd50, 1'b0, 16'd0);
    send_request(CMD_READ, 16'sd0, 16'sd0, 1'b0, 16'hFFFF);
    run_random(150);
    settle();

    // Scale 1000 with the largest range and grid.
    apply_settings(1000, 32767, 32767, 256, 256);
    run_random(250);
    settle();

    // Zero scale, zero half width, sides held at one and at the largest side.
    idling = 1'b0;
    apply_settings(15'h7C00, 0, 32767, 15'h7E00, 511);
    write_register(CFG_SPARE, 15'h7FFF);
    run_random(80);
    settle();

    // Smallest non-zero scale on a tiny grid.
    idling = 1'b1;
    apply_settings(1, 32767, 32767, 3, 2);
    run_random(200);
    settle();

    // Random settings.
    repeat (2) begin
      apply_settings($urandom_range(1000, 1), $urandom_range(32767, 200),
                     $urandom_range(32767, 200), $urandom_range(256, 1),
                     $urandom_range(256, 1));
      run_random(250);
      settle();
    end

    // Final stretch at full rate on both sides.
    idling = 1'b0;
    apply_settings(100, 5000, 3000, 16, 12);
    run_random(300);
    settle();

    if (sb.error_count == 0 && sb.pending() == 0)
      $display("tb_point_occupancy_grid_marker_top: done, clean");
    else
      $display("tb_point_occupancy_grid_marker_top: done, errors");
    $finish;
  end

endmodule

### sim.f
hdl/pomg_pkg.sv
hdl/pomg_ram.sv
hdl/pomg_fifo.sv
hdl/pomg_front.sv
hdl/pomg_back.sv
hdl/point_occupancy_grid_marker_top.sv
dv/tb_point_occupancy_grid_marker_top.sv
